// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the text console writer modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the rising clock edge, skipped while reset is high
`define TCW_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on the rising clock edge, also while reset is high
`define TCW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/tcw_pkg.sv =====
// Shared types and constants of the text console character writer
package tcw_pkg;

  localparam int CHAR_W = 8;
  localparam int CELL_W = 16;
  localparam int POS_W  = 11;
  localparam int ADDR_IN_W = 11;

  localparam logic [CHAR_W-1:0] RESET_ATTR = 8'h07;
  localparam int TAB_STEP = 8;

  // control bytes
  localparam logic [CHAR_W-1:0] CHAR_TAB = 8'd9;
  localparam logic [CHAR_W-1:0] CHAR_LF  = 8'd10;
  localparam logic [CHAR_W-1:0] CHAR_CR  = 8'd13;

  // item modes
  localparam logic MODE_PUT  = 1'b0;
  localparam logic MODE_READ = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic sweep_clear;
    logic sweep_scroll;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_scroll;
    logic sweep_done;
  } status_t;

endpackage

// ===== rtl/tcw_ram.sv =====
// Generic simple dual port RAM with registered read
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write one word, read one word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/tcw_ctrl.sv =====
// Controller state machine of the text console character writer
`include "assert_macros.svh"

module tcw_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  tcw_pkg::status_t status,
  output tcw_pkg::cmd_t    cmd,
  output logic             busy,
  output logic             result_valid
);

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_SCROLL = 4'b0100,
    ST_REPLY  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  // take a word while idle or while the previous result is shown
  assign busy   = rst || !(state == ST_IDLE || state == ST_REPLY);
  assign accept = start && !busy;

  assign cmd.accept       = accept;
  assign cmd.sweep_clear  = (state == ST_CLEAR);
  assign cmd.sweep_scroll = (state == ST_SCROLL);
  assign result_valid     = (state == ST_REPLY);

  // advance the controller
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (status.sweep_done) state_next = ST_IDLE;
      end
      ST_IDLE, ST_REPLY: begin
        if (accept) begin
          state_next = status.need_scroll ? ST_SCROLL : ST_REPLY;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_SCROLL: begin
        if (status.sweep_done) state_next = ST_REPLY;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  `TCW_ASSERT(a_scroll_holds_off, clk, rst, accept && status.need_scroll |=> busy && !result_valid, "scroll did not stall")
  `TCW_ASSERT(a_plain_replies, clk, rst, accept && !status.need_scroll |=> result_valid, "missing result after word")

endmodule

// ===== rtl/tcw_datapath.sv =====
// Datapath of the text console character writer: cursor, screen store, sweeps
`include "assert_macros.svh"

module tcw_datapath #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                            clk,
  input  logic                            rst,
  input  tcw_pkg::cmd_t                   cmd,
  output tcw_pkg::status_t                status,
  input  logic                            mode,
  input  logic [tcw_pkg::CHAR_W-1:0]      char_code,
  input  logic [tcw_pkg::ADDR_IN_W-1:0]   cell_address,
  input  logic                            text_attribute_wr_en,
  input  logic [tcw_pkg::CHAR_W-1:0]      text_attribute,
  output logic [tcw_pkg::POS_W-1:0]       cursor_position,
  output logic [tcw_pkg::CHAR_W-1:0]      read_char,
  output logic [tcw_pkg::CHAR_W-1:0]      read_attr
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(CELLS + 1);
  localparam int CLW   = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam logic [CLW:0]   TAB_MASK = (CLW+1)'(tcw_pkg::TAB_STEP - 1);
  localparam logic [CLW:0]   TAB_INC  = (CLW+1)'(tcw_pkg::TAB_STEP);
  localparam logic [CLW:0]   COL_END  = (CLW+1)'(COLUMNS);
  localparam logic [RW-1:0]  ROW_LAST = RW'(ROWS - 1);
  localparam logic [CW-1:0]  CNT_CLEAR_LAST  = CW'(CELLS - 1);
  localparam logic [CW-1:0]  CNT_SCROLL_LAST = CW'(CELLS);
  localparam logic [CW-1:0]  CNT_COPY_LAST   = CW'(CELLS - COLUMNS);

  logic [CLW-1:0]              col;
  logic [RW-1:0]               row;
  logic [AW-1:0]               row_base;
  logic [tcw_pkg::CHAR_W-1:0]  attr;
  logic [CW-1:0]               cnt;
  logic                        reply_read;

  logic                        is_newline;
  logic                        is_tab;
  logic                        is_print;
  logic                        put_word;
  logic                        read_word;
  logic [CLW:0]                col_ext;
  logic [CLW:0]                col_step;
  logic                        wrap;
  logic                        last_row;
  logic [31:0]                 pos_sum;
  logic [31:0]                 base_sum;
  logic [31:0]                 addr_ext;
  logic                        addr_ok;
  logic [CW:0]                 src_sum;
  logic [CW-1:0]               cnt_prev;
  logic                        sweep_done;

  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [tcw_pkg::CELL_W-1:0]  ram_wdata;
  logic [AW-1:0]               ram_raddr;
  logic [tcw_pkg::CELL_W-1:0]  ram_rdata;

  // decode the word
  assign is_newline = (char_code == tcw_pkg::CHAR_LF) || (char_code == tcw_pkg::CHAR_CR);
  assign is_tab     = (char_code == tcw_pkg::CHAR_TAB);
  assign is_print   = !is_newline && !is_tab;
  assign put_word   = cmd.accept && (mode == tcw_pkg::MODE_PUT);
  assign read_word  = cmd.accept && (mode == tcw_pkg::MODE_READ);

  // next column and row wrap
  assign col_ext  = (CLW+1)'(col);
  assign col_step = is_print ? col_ext + (CLW+1)'(1) : (col_ext & ~TAB_MASK) + TAB_INC;
  assign wrap     = is_newline || (col_step >= COL_END);
  assign last_row = (row == ROW_LAST);

  assign status.need_scroll = put_word && wrap && last_row;

  // linear positions
  assign pos_sum  = 32'(row_base) + 32'(col);
  assign base_sum = 32'(row_base) + 32'(COLUMNS);
  assign addr_ext = 32'(cell_address);
  assign addr_ok  = (addr_ext < 32'(CELLS));

  assign cursor_position = pos_sum[tcw_pkg::POS_W-1:0];

  // sweep counter: clearing pass and scroll copy
  assign src_sum    = (CW+1)'(cnt) + (CW+1)'(COLUMNS);
  assign cnt_prev   = cnt - CW'(1);
  assign sweep_done = (cmd.sweep_clear && (cnt == CNT_CLEAR_LAST))
                   || (cmd.sweep_scroll && (cnt == CNT_SCROLL_LAST));
  assign status.sweep_done = sweep_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.sweep_clear || cmd.sweep_scroll) begin
      cnt <= sweep_done ? '0 : cnt + CW'(1);
    end
  end

  // select the store write
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pos_sum[AW-1:0];
    ram_wdata = {attr, char_code};
    if (cmd.sweep_clear) begin
      ram_we    = 1'b1;
      ram_waddr = cnt[AW-1:0];
      ram_wdata = {tcw_pkg::RESET_ATTR, tcw_pkg::CHAR_W'(0)};
    end else if (cmd.sweep_scroll) begin
      ram_we    = (cnt != '0);
      ram_waddr = cnt_prev[AW-1:0];
      ram_wdata = (cnt <= CNT_COPY_LAST) ? ram_rdata : {attr, tcw_pkg::CHAR_W'(0)};
    end else if (put_word && is_print) begin
      ram_we = 1'b1;
    end
  end

  // select the store read
  assign ram_raddr = cmd.sweep_scroll ? src_sum[AW-1:0] : addr_ext[AW-1:0];

  tcw_ram #(
    .WIDTH(tcw_pkg::CELL_W),
    .DEPTH(CELLS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // advance the cursor
  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      row_base <= '0;
    end else if (put_word) begin
      if (wrap) begin
        col <= '0;
        if (!last_row) begin
          row      <= row + RW'(1);
          row_base <= base_sum[AW-1:0];
        end
      end else begin
        col <= col_step[CLW-1:0];
      end
    end
  end

  // hold the attribute register
  always_ff @(posedge clk) begin
    if (rst) begin
      attr <= tcw_pkg::RESET_ATTR;
    end else if (text_attribute_wr_en) begin
      attr <= text_attribute;
    end
  end

  // mark a result that carries cell data
  always_ff @(posedge clk) begin
    if (rst) begin
      reply_read <= 1'b0;
    end else if (cmd.accept) begin
      reply_read <= read_word && addr_ok;
    end
  end

  assign read_char = reply_read ? ram_rdata[tcw_pkg::CHAR_W-1:0] : '0;
  assign read_attr = reply_read ? ram_rdata[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W] : '0;

  `TCW_ASSERT(a_cursor_in_screen, clk, rst, (32'(col) < 32'(COLUMNS)) && (32'(row) < 32'(ROWS)), "cursor left the screen")
  `TCW_ASSERT(a_count_idle, clk, rst, !cmd.sweep_clear && !cmd.sweep_scroll |-> cnt == '0, "sweep count not parked")

endmodule

// ===== rtl/text_console_char_writer.sv =====
// Top level of the text console character writer
//
//  channel   | handshake                  | word
//  ----------+----------------------------+-------------------------------------------
//  input     | start, busy                | mode, char_code, cell_address
//  result    | result_valid (one cycle)   | cursor_position, read_char, read_attr
//  config    | text_attribute_wr_en       | text_attribute
//
// A word is taken when start is high and busy is low; a plain word's result shows in the cycle after.
// A new word may be taken in the cycle that shows the result, so plain words run at one a cycle.
// A newline or a column wrap on the bottom row scrolls: the store is copied one cell a cycle
// with busy high, then the result shows.
// After reset a clearing pass writes every cell with busy high.
// The receiver cannot stall; each result is valid for exactly one cycle.
module text_console_char_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           mode,
  input  logic [tcw_pkg::CHAR_W-1:0]     char_code,
  input  logic [tcw_pkg::ADDR_IN_W-1:0]  cell_address,
  output logic                           result_valid,
  output logic [tcw_pkg::POS_W-1:0]      cursor_position,
  output logic [tcw_pkg::CHAR_W-1:0]     read_char,
  output logic [tcw_pkg::CHAR_W-1:0]     read_attr,
  input  logic                           text_attribute_wr_en,
  input  logic [tcw_pkg::CHAR_W-1:0]     text_attribute
);

  tcw_pkg::cmd_t    cmd;
  tcw_pkg::status_t status;

  tcw_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .status      (status),
    .cmd         (cmd),
    .busy        (busy),
    .result_valid(result_valid)
  );

  tcw_datapath #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_datapath (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .status              (status),
    .mode                (mode),
    .char_code           (char_code),
    .cell_address        (cell_address),
    .text_attribute_wr_en(text_attribute_wr_en),
    .text_attribute      (text_attribute),
    .cursor_position     (cursor_position),
    .read_char           (read_char),
    .read_attr           (read_attr)
  );

endmodule

// ===== verif/text_console_char_writer_tb.sv =====
// Self-checking testbench for the text console character writer
module text_console_char_writer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;
  localparam int PHASES  = 6;
  localparam int PHASE_WORDS = 250;
  localparam int DIRECTED_ROWS = 24;
  localparam int TAIL_CYCLES = 2100;

  // one result word as it leaves the block
  typedef struct packed {
    logic [tcw_pkg::POS_W-1:0]  pos;
    logic [tcw_pkg::CHAR_W-1:0] rd_char;
    logic [tcw_pkg::CHAR_W-1:0] rd_attr;
  } console_result_t;

  typedef enum bit {ROW_WORD, ROW_ATTR} row_kind_t;

  // directed step: one word (repeated reps times) or one attribute write
  typedef struct packed {
    row_kind_t                     kind;
    logic                          mode;
    logic [tcw_pkg::CHAR_W-1:0]    value;
    logic [tcw_pkg::ADDR_IN_W-1:0] addr;
    logic [5:0]                    reps;
    logic                          lit;
    logic [tcw_pkg::POS_W-1:0]     want_pos;
    logic [tcw_pkg::CHAR_W-1:0]    want_char;
    logic [tcw_pkg::CHAR_W-1:0]    want_attr;
  } step_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic mode = tcw_pkg::MODE_PUT;
  logic [tcw_pkg::CHAR_W-1:0] char_code = '0;
  logic [tcw_pkg::ADDR_IN_W-1:0] cell_address = '0;
  logic result_valid;
  logic [tcw_pkg::POS_W-1:0] cursor_position;
  logic [tcw_pkg::CHAR_W-1:0] read_char;
  logic [tcw_pkg::CHAR_W-1:0] read_attr;
  logic text_attribute_wr_en = 1'b0;
  logic [tcw_pkg::CHAR_W-1:0] text_attribute = '0;

  // literal expectation that rides along with a directed word
  logic lit_valid = 1'b0;
  console_result_t lit_word = '0;

  console_result_t expected_words[$];
  int error_count = 0;

  // shadow copy of the screen, cursor and attribute register
  logic [tcw_pkg::CHAR_W-1:0] shadow_char [0:CELLS-1];
  logic [tcw_pkg::CHAR_W-1:0] shadow_attr [0:CELLS-1];
  int shadow_col;
  int shadow_row;
  logic [tcw_pkg::CHAR_W-1:0] shadow_text_attr;

  step_row_t directed_table [DIRECTED_ROWS] = '{
    // reads right after the clearing pass, in and out of range
    '{ROW_WORD, tcw_pkg::MODE_READ, 8'd0, 11'd0, 6'd1, 1'b1, 11'd0, 8'd0, tcw_pkg::RESET_ATTR},
    '{ROW_WORD, tcw_pkg::MODE_READ, 8'd255, 11'd1999, 6'd1, 1'b1, 11'd0, 8'd0,
      tcw_pkg::RESET_ATTR},
    '{ROW_WORD, tcw_pkg::MODE_READ, 8'd0, 11'd2000, 6'd1, 1'b1, 11'd0, 8'd0, 8'h00},
    '{ROW_WORD, tcw_pkg::MODE_READ, 8'd0, 11'd2047, 6'd1, 1'b1, 11'd0, 8'd0, 8'h00},
    '{ROW_ATTR, tcw_pkg::MODE_PUT, 8'h00, 11'd0, 6'd1, 1'b0, 11'd0, 8'd0, 8'h00},
    // printable extremes, then read one back
    '{ROW_WORD, tcw_pkg::MODE_PUT, 8'd65, 11'd2047, 6'd1, 1'b1, 11'd1, 8'd0, 8'h00},
    '{ROW_WORD, tcw_pkg::MODE_PUT, 8'd0, 11'd0, 6'd1, 1'b1, 11'd2, 8'd0, 8'h00},
    '{ROW_WORD, tcw_pkg::MODE_PUT, 8'd255, 11'd0, 6'd1, 1'b1, 11'd3, 8'd0, 8'h00},
    '{ROW_WORD, tcw_pkg::MODE_READ, 8'd0, 11'd0, 6'd1, 1'b1, 11'd3, 8'd65, 8'h00},
    // controls
    '{ROW_WORD, tcw_pkg::MODE_PUT, tcw_pkg::CHAR_TAB, 11'd0, 6'd1, 1'b1, 11'd8, 8'd0, 8'h00},
    '{ROW_WORD, tcw_pkg::MODE_PUT, tcw_pkg::CHAR_TAB, 11'd0, 6'd1, 1'b1, 11'd16, 8'd0, 8'h00},
    '{ROW_WORD, tcw_pkg::MODE_PUT, tcw_pkg::CHAR_CR, 11'd0, 6'd1, 1'b1, 11'd80, 8'd0, 8'h00},
    '{ROW_WORD, tcw_pkg::MODE_PUT, tcw_pkg::CHAR_LF, 11'd0, 6'd1, 1'b1, 11'd160, 8'd0, 8'h00},
    '{ROW_WORD, tcw_pkg::MODE_PUT, 8'd8, 11'd0, 6'd1, 1'b0, 11'd0, 8'd0, 8'h00},
    '{ROW_WORD, tcw_pkg::MODE_PUT, 8'd11, 11'd0, 6'd1, 1'b0, 11'd0, 8'd0, 8'h00},
    '{ROW_ATTR, tcw_pkg::MODE_PUT, 8'hff, 11'd0, 6'd1, 1'b0, 11'd0, 8'd0, 8'h00},
    // walk down to the bottom row, then wrap a tab into a scroll
    '{ROW_WORD, tcw_pkg::MODE_PUT, tcw_pkg::CHAR_LF, 11'd0, 6'd22, 1'b0, 11'd0, 8'd0, 8'h00},
    '{ROW_WORD, tcw_pkg::MODE_PUT, tcw_pkg::CHAR_TAB, 11'd0, 6'd10, 1'b0, 11'd0, 8'd0, 8'h00},
    // scrolled row uses the current attribute, older rows keep the reset one
    '{ROW_WORD, tcw_pkg::MODE_READ, 8'd0, 11'd1999, 6'd1, 1'b1, 11'd1920, 8'd0, 8'hff},
    '{ROW_WORD, tcw_pkg::MODE_READ, 8'd0, 11'd0, 6'd1, 1'b1, 11'd1920, 8'd0,
      tcw_pkg::RESET_ATTR},
    '{ROW_WORD, tcw_pkg::MODE_PUT, tcw_pkg::CHAR_LF, 11'd0, 6'd1, 1'b1, 11'd1920, 8'd0, 8'h00},
    '{ROW_WORD, tcw_pkg::MODE_PUT, 8'd127, 11'd0, 6'd1, 1'b1, 11'd1921, 8'd0, 8'h00},
    '{ROW_WORD, tcw_pkg::MODE_READ, 8'd0, 11'd1920, 6'd1, 1'b1, 11'd1921, 8'd127, 8'hff},
    '{ROW_WORD, tcw_pkg::MODE_READ, 8'd0, 11'd1, 6'd1, 1'b0, 11'd0, 8'd0, 8'h00}
  };

  text_console_char_writer #(
    .COLUMNS(COLUMNS),
    .ROWS(ROWS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .mode(mode),
    .char_code(char_code),
    .cell_address(cell_address),
    .result_valid(result_valid),
    .cursor_position(cursor_position),
    .read_char(read_char),
    .read_attr(read_attr),
    .text_attribute_wr_en(text_attribute_wr_en),
    .text_attribute(text_attribute)
  );

  always #4 clk = ~clk;

  // move to column 0 of the next row, scrolling on the bottom row
  function automatic void line_feed();
    shadow_col = 0;
    if (shadow_row + 1 >= ROWS) begin
      shadow_row = ROWS - 1;
      for (int i = 0; i < CELLS - COLUMNS; i++) begin
        shadow_char[i] = shadow_char[i + COLUMNS];
        shadow_attr[i] = shadow_attr[i + COLUMNS];
      end
      for (int i = CELLS - COLUMNS; i < CELLS; i++) begin
        shadow_char[i] = '0;
        shadow_attr[i] = shadow_text_attr;
      end
    end else begin
      shadow_row++;
    end
  endfunction

  // apply one word to the shadow console and return its result word
  function automatic console_result_t console_step(input logic m,
                                                   input logic [tcw_pkg::CHAR_W-1:0] c,
                                                   input logic [tcw_pkg::ADDR_IN_W-1:0] a);
    console_result_t r;
    int pos;
    r = '0;
    if (m == tcw_pkg::MODE_READ) begin
      if (a < CELLS) begin
        r.rd_char = shadow_char[a];
        r.rd_attr = shadow_attr[a];
      end
    end else if (c == tcw_pkg::CHAR_LF || c == tcw_pkg::CHAR_CR) begin
      line_feed();
    end else if (c == tcw_pkg::CHAR_TAB) begin
      shadow_col = (shadow_col & ~(tcw_pkg::TAB_STEP - 1)) + tcw_pkg::TAB_STEP;
      if (shadow_col >= COLUMNS) line_feed();
    end else begin
      pos = shadow_row * COLUMNS + shadow_col;
      if (pos < CELLS) begin
        shadow_char[pos] = c;
        shadow_attr[pos] = shadow_text_attr;
      end
      shadow_col++;
      if (shadow_col >= COLUMNS) line_feed();
    end
    pos = shadow_row * COLUMNS + shadow_col;
    r.pos = pos[tcw_pkg::POS_W-1:0];
    return r;
  endfunction

  // check result words against the oldest expectation, then predict accepted words
  always @(posedge clk) begin : monitor
    console_result_t want;
    if (rst !== 1'b1) begin
      if (result_valid === 1'b1) begin
        if (expected_words.size() == 0) begin
          $error("result word with no expectation waiting: pos %0d char %0d attr %0d",
                 cursor_position, read_char, read_attr);
          error_count++;
        end else begin
          want = expected_words.pop_front();
          if (cursor_position !== want.pos) begin
            $error("cursor_position: expected %0d, actual %0d", want.pos, cursor_position);
            error_count++;
          end
          if (read_char !== want.rd_char) begin
            $error("read_char: expected %0d, actual %0d", want.rd_char, read_char);
            error_count++;
          end
          if (read_attr !== want.rd_attr) begin
            $error("read_attr: expected %0d, actual %0d", want.rd_attr, read_attr);
            error_count++;
          end
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        want = console_step(mode, char_code, cell_address);
        if (lit_valid) want = lit_word;
        expected_words.push_back(want);
      end
      if (text_attribute_wr_en === 1'b1) shadow_text_attr = text_attribute;
    end
  end

  // drive one word and hold it until the block takes it
  task automatic send_word(input logic m, input logic [tcw_pkg::CHAR_W-1:0] c,
                           input logic [tcw_pkg::ADDR_IN_W-1:0] a, input logic lit,
                           input console_result_t want);
    @(negedge clk);
    start <= 1'b1;
    mode <= m;
    char_code <= c;
    cell_address <= a;
    lit_valid <= lit;
    lit_word <= want;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // drop start and hold it low for the length given by n
  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // write the attribute register once all results are in
  task automatic write_attr(input logic [tcw_pkg::CHAR_W-1:0] value);
    @(negedge clk);
    start <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (2) @(negedge clk);
    text_attribute_wr_en <= 1'b1;
    text_attribute <= value;
    @(negedge clk);
    text_attribute_wr_en <= 1'b0;
  endtask

  initial begin : stimulus
    int sel;
    int gap;
    int base;
    logic m;
    logic [tcw_pkg::CHAR_W-1:0] c;
    logic [tcw_pkg::ADDR_IN_W-1:0] a;
    logic [tcw_pkg::CHAR_W-1:0] attr_value;

    // shadow state after reset
    for (int i = 0; i < CELLS; i++) begin
      shadow_char[i] = '0;
      shadow_attr[i] = tcw_pkg::RESET_ATTR;
    end
    shadow_col = 0;
    shadow_row = 0;
    shadow_text_attr = tcw_pkg::RESET_ATTR;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table
    foreach (directed_table[r]) begin
      if (directed_table[r].kind == ROW_ATTR) begin
        write_attr(directed_table[r].value);
      end else begin
        repeat (directed_table[r].reps)
          send_word(directed_table[r].mode, directed_table[r].value, directed_table[r].addr,
                    directed_table[r].lit, {directed_table[r].want_pos,
                    directed_table[r].want_char, directed_table[r].want_attr});
      end
    end

    // random phases, each under its own attribute
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: attr_value = 8'h00;
        1: attr_value = 8'hff;
        default: attr_value = tcw_pkg::CHAR_W'($urandom_range(0, 255));
      endcase
      write_attr(attr_value);
      for (int k = 0; k < PHASE_WORDS; k++) begin
        sel = $urandom_range(0, 99);
        c = tcw_pkg::CHAR_W'($urandom_range(0, 255));
        a = tcw_pkg::ADDR_IN_W'($urandom_range(0, 2047));
        m = tcw_pkg::MODE_PUT;
        if (sel < 20) begin
          // read near the cursor, anywhere on screen, or past the end
          m = tcw_pkg::MODE_READ;
          gap = $urandom_range(0, 9);
          if (gap < 5) begin
            base = shadow_row * COLUMNS + shadow_col - int'($urandom_range(0, 40));
            a = (base < 0) ? '0 : base[tcw_pkg::ADDR_IN_W-1:0];
          end else if (gap < 9) begin
            a = tcw_pkg::ADDR_IN_W'($urandom_range(0, CELLS - 1));
          end else begin
            a = tcw_pkg::ADDR_IN_W'($urandom_range(CELLS, 2047));
          end
        end else if (sel < 26) begin
          c = tcw_pkg::CHAR_LF;
        end else if (sel < 29) begin
          c = tcw_pkg::CHAR_CR;
        end else if (sel < 35) begin
          c = tcw_pkg::CHAR_TAB;
        end
        send_word(m, c, a, 1'b0, '0);
        // mostly short gaps, a few long; every third phase runs back to back
        if (p % 3 != 2) begin
          sel = $urandom_range(0, 99);
          if (sel < 60) gap = 0;
          else if (sel < 88) gap = $urandom_range(1, 3);
          else if (sel < 97) gap = $urandom_range(4, 20);
          else gap = $urandom_range(30, 100);
          if (gap > 0) idle_cycles(gap);
        end
      end
    end

    // drain and let the block settle
    idle_cycles(1);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_words.size() != 0) begin
      $error("%0d expected result words never arrived", expected_words.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // guard against a hung handshake
  initial begin : watchdog
    #100_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
